/* hdl/hash_table_linear_probe_assert.svh */
// ----------------------------------------------------------------------------
// Hash table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HASH_TABLE_LINEAR_PROBE_ASSERT_SVH
`define HASH_TABLE_LINEAR_PROBE_ASSERT_SVH

// Same-cycle implication.
`define HTLP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htlp: same-cycle check failed");

// Next-cycle implication.
`define HTLP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htlp: next-cycle check failed");

`endif

/* hdl/htlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table package
// Sizes, codes and payload types shared by the hash table modules.
// ----------------------------------------------------------------------------
package htlp_pkg;

  localparam int CAPACITY  = 1024;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = IDX_W + 1;
  localparam int KEY_BYTES = 8;
  localparam int LEN_W     = 4;
  localparam int KEY_W     = 64;
  localparam int VAL_W     = 64;
  localparam int LIVE_W    = 11;
  // Hash arithmetic only needs the low index bits, but a whole byte is mixed in.
  localparam int HX_W      = (IDX_W > 8) ? IDX_W : 8;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE     = 2'd0,
    STS_NOTFOUND = 2'd1,
    STS_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_LIVE  = 2'd1,
    KIND_TOMB  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key_bytes;
    logic [LEN_W-1:0] key_len;
    logic [VAL_W-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [VAL_W-1:0]  read_value;
    logic [LIVE_W-1:0] live_total;
  } out_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] key_len;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } wr_t;

endpackage

/* hdl/hash_table_linear_probe.sv */
`timescale 1ns / 1ps
// Each accepted transaction is hashed one key byte at a time, then probes slot by slot, then registers its result.
// Throughput: one transaction at a time; the next is accepted once the result is registered.
// The probe loop visits each slot in a read state and then a check state, since the slot memory read is registered.
// After reset a clearing pass empties every slot; input stalls meanwhile.
// ----------------------------------------------------------------------------
// Hash table with linear probing
// Open-addressing key-value table keyed by up to eight bytes, FNV-1a hashed.
// ----------------------------------------------------------------------------
`include "hash_table_linear_probe_assert.svh"

module hash_table_linear_probe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  htlp_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output htlp_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [htlp_pkg::LIVE_W-1:0]   cfg_wdata
);

  // One-hot controller states.
  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_HASH   = 6'b000100,
    S_READ   = 6'b001000,
    S_CHECK  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [htlp_pkg::IDX_W-1:0]      clr_r, clr_nxt;
  logic [1:0]                      cmd_r, cmd_nxt;
  logic [htlp_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [htlp_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [htlp_pkg::VAL_W-1:0]      val_r, val_nxt;
  logic [htlp_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [htlp_pkg::CNT_W-1:0]      n_r, n_nxt;
  logic                            tomb_r, tomb_nxt;
  logic [htlp_pkg::IDX_W-1:0]      tomb_idx_r, tomb_idx_nxt;
  logic                            empty_r, empty_nxt;
  logic                            hit_r, hit_nxt;
  logic [htlp_pkg::VAL_W-1:0]      hit_val_r, hit_val_nxt;
  logic [htlp_pkg::LIVE_W-1:0]     live_r, live_nxt;
  logic [htlp_pkg::LIVE_W-1:0]     max_r;
  logic                            out_valid_r, out_valid_nxt;
  htlp_pkg::out_item_t             out_item_r, out_item_nxt;

  logic                            accept;
  logic                            out_free;
  logic [htlp_pkg::LEN_W-1:0]      len_c;
  logic [htlp_pkg::KEY_W-1:0]      key_c;
  logic                            hash_done;
  logic [htlp_pkg::IDX_W-1:0]      hash_idx;
  htlp_pkg::wr_t                   wr;
  htlp_pkg::slot_t                 rd_data;
  logic                            key_match;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Lengths beyond the key width act as a full key; bytes above the length are zeroed.
  always_comb begin
    len_c = (in_item.key_len > htlp_pkg::LEN_W'(htlp_pkg::KEY_BYTES)) ?
            htlp_pkg::LEN_W'(htlp_pkg::KEY_BYTES) : in_item.key_len;
    key_c = in_item.key_bytes;
    for (int i = 0; i < htlp_pkg::KEY_BYTES; i++) begin
      if (htlp_pkg::LEN_W'(i) >= len_c) begin
        key_c[i*8 +: 8] = 8'h00;
      end
    end
  end

  htlp_hash u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .key     (key_r),
    .key_len (len_r),
    .done    (hash_done),
    .idx     (hash_idx)
  );

  htlp_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign key_match = (rd_data.key_len == len_r) && (rd_data.key == key_r);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    len_nxt       = len_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    tomb_nxt      = tomb_r;
    tomb_idx_nxt  = tomb_idx_r;
    empty_nxt     = empty_r;
    hit_nxt       = hit_r;
    hit_val_nxt   = hit_val_r;
    live_nxt      = live_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    wr            = '0;

    unique case (state_r)
      S_CLEAR: begin
        // Sweep every slot to empty, one per cycle.
        wr.en   = 1'b1;
        wr.addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {htlp_pkg::IDX_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_item.cmd;
          key_nxt   = key_c;
          len_nxt   = len_c;
          val_nxt   = in_item.new_value;
          tomb_nxt  = 1'b0;
          empty_nxt = 1'b0;
          hit_nxt   = 1'b0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          idx_nxt   = hash_idx;
          n_nxt     = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (rd_data.kind == htlp_pkg::KIND_EMPTY) begin
          empty_nxt = 1'b1;
          state_nxt = S_FINISH;
        end else if (rd_data.kind == htlp_pkg::KIND_LIVE && key_match) begin
          hit_nxt     = 1'b1;
          hit_val_nxt = rd_data.value;
          state_nxt   = S_FINISH;
        end else begin
          if (rd_data.kind == htlp_pkg::KIND_TOMB && !tomb_r) begin
            tomb_nxt     = 1'b1;
            tomb_idx_nxt = idx_r;
          end
          idx_nxt = idx_r + 1'b1;
          n_nxt   = n_r + 1'b1;
          if (n_r == htlp_pkg::CNT_W'(htlp_pkg::CAPACITY - 1)) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_item_nxt.status     = htlp_pkg::STS_DONE;
          out_item_nxt.found      = hit_r;
          out_item_nxt.read_value = '0;
          wr.data.key             = key_r;
          wr.data.key_len         = len_r;
          wr.data.value           = val_r;
          wr.data.kind            = htlp_pkg::KIND_LIVE;
          wr.addr                 = idx_r;
          case (cmd_r)
            htlp_pkg::CMD_INSERT: begin
              if (hit_r) begin
                wr.en = 1'b1;
              end else if (({1'b0, live_r} + 1'b1) > {1'b0, max_r} ||
                           (!tomb_r && !empty_r)) begin
                out_item_nxt.status = htlp_pkg::STS_FULL;
              end else begin
                wr.en    = 1'b1;
                wr.addr  = tomb_r ? tomb_idx_r : idx_r;
                live_nxt = live_r + 1'b1;
              end
            end
            htlp_pkg::CMD_DELETE: begin
              if (hit_r) begin
                wr.en         = 1'b1;
                wr.data.kind  = htlp_pkg::KIND_TOMB;
                wr.data.value = '0;
                live_nxt      = live_r - 1'b1;
              end else begin
                out_item_nxt.status = htlp_pkg::STS_NOTFOUND;
              end
            end
            default: begin
              // Lookup, and the unused command code behaves the same way.
              if (hit_r) begin
                out_item_nxt.read_value = hit_val_r;
              end else begin
                out_item_nxt.status = htlp_pkg::STS_NOTFOUND;
              end
            end
          endcase
          out_item_nxt.live_total = live_nxt;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      live_r      <= '0;
      max_r       <= htlp_pkg::LIVE_W'(768);
      out_valid_r <= 1'b0;
      tomb_r      <= 1'b0;
      empty_r     <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
      tomb_r      <= tomb_nxt;
      empty_r     <= empty_nxt;
      hit_r       <= hit_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    len_r      <= len_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    tomb_idx_r <= tomb_idx_nxt;
    hit_val_r  <= hit_val_nxt;
    out_item_r <= out_item_nxt;
  end

  // The live count never exceeds the number of slots.
  `HTLP_ASSERT_IMP(a_live_bound, 1'b1, live_r <= htlp_pkg::LIVE_W'(htlp_pkg::CAPACITY))
  // No slot is written while a probe is reading the memory.
  `HTLP_ASSERT_IMP(a_no_wr_probe, state_r == S_READ || state_r == S_CHECK, !wr.en)
  // The live count moves only when a transaction finishes.
  `HTLP_ASSERT_NXT(a_live_hold, state_r != S_FINISH, $stable(live_r))

endmodule

/* hdl/htlp_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table FNV-1a index unit
// Folds one key byte per cycle into the low index bits of the FNV-1a hash.
// ----------------------------------------------------------------------------
module htlp_hash (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [htlp_pkg::KEY_W-1:0]                 key,
  input  logic [htlp_pkg::LEN_W-1:0]                 key_len,
  output logic                                       done,
  output logic [htlp_pkg::IDX_W-1:0]                 idx
);

  logic                             busy_r, busy_nxt;
  logic [htlp_pkg::LEN_W-1:0]       cnt_r, cnt_nxt;
  logic [htlp_pkg::IDX_W-1:0]       h_r, h_nxt;
  logic [7:0]                       byte_c;
  logic [htlp_pkg::HX_W-1:0]        hx_c;
  logic [2*htlp_pkg::HX_W-1:0]      prod_c;

  // Low bits of a product depend only on low bits of the operands.
  assign byte_c = key[cnt_r[2:0]*8 +: 8];
  assign hx_c   = htlp_pkg::HX_W'(h_r) ^ htlp_pkg::HX_W'(byte_c);
  assign prod_c = hx_c * htlp_pkg::FNV_PRIME[htlp_pkg::HX_W-1:0];
  assign done   = busy_r && (cnt_r == key_len);
  assign idx    = h_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    h_nxt    = h_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      h_nxt    = htlp_pkg::FNV_BASIS[htlp_pkg::IDX_W-1:0];
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      h_nxt   = prod_c[htlp_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    h_r <= h_nxt;
  end

endmodule

/* hdl/htlp_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table slot memory
// One write port and one registered read port over all slots.
// ----------------------------------------------------------------------------
module htlp_mem (
  input  logic                        clk,
  input  htlp_pkg::wr_t               wr,
  input  logic [htlp_pkg::IDX_W-1:0]  rd_addr,
  output htlp_pkg::slot_t             rd_data
);

  htlp_pkg::slot_t mem [htlp_pkg::CAPACITY];
  htlp_pkg::slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
